// File: hdl/ppim0_pkg.sv
// ----------------------------------------------------------------------------
// ppim0_pkg
// Shared types and codes for the three-port parallel I/O block (mode 0).
// ----------------------------------------------------------------------------
package ppim0_pkg;

	localparam int NUM_PORTS = 3;

	// bus action codes
	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	// register offsets
	localparam logic [2:0] ADDR_PORT_A = 3'd0;
	localparam logic [2:0] ADDR_PORT_B = 3'd1;
	localparam logic [2:0] ADDR_PORT_C = 3'd2;
	localparam logic [2:0] ADDR_CTL    = 3'd3;

	// port indexes
	localparam logic [1:0] PORT_A = 2'd0;
	localparam logic [1:0] PORT_B = 2'd1;
	localparam logic [1:0] PORT_C = 2'd2;

	// control word fields
	localparam int CTL_MODE_SET_BIT = 7;
	localparam int CTL_DIR_A_BIT    = 4;
	localparam int CTL_DIR_CU_BIT   = 3;
	localparam int CTL_DIR_B_BIT    = 1;
	localparam int CTL_DIR_CL_BIT   = 0;

	localparam logic [7:0] READ_UNUSED = 8'hFF;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic                        action;
		logic [2:0]                  address;
		byte_t                       write_data;
		logic [NUM_PORTS-1:0][7:0]   pins;
	} item_t;

	typedef struct packed {
		byte_t                       read_data;
		logic [NUM_PORTS-1:0][7:0]   drive;
		logic [NUM_PORTS-1:0][7:0]   changed;
		logic [NUM_PORTS-1:0]        touched;
	} res_t;

endpackage

// File: hdl/ppim0_core.sv
// ----------------------------------------------------------------------------
// ppim0_core
// Port latches, directions and drives, with the access decode that updates
// them and forms the result of one item.
// ----------------------------------------------------------------------------
module ppim0_core
	import ppim0_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  advance,
	input  item_t item,
	output res_t  res
);

	logic [NUM_PORTS-1:0][7:0] latch_q, latch_d;
	logic [NUM_PORTS-1:0][7:0] dir_q, dir_d;
	logic [NUM_PORTS-1:0][7:0] drive_q, drive_d;
	logic [NUM_PORTS-1:0]      touched;
	byte_t                     rd;
	logic [2:0]                bit_sel;
	logic [1:0]                pidx;

	function automatic byte_t eval_drive(input byte_t latch, input byte_t dir);
		eval_drive = (latch & ~dir) | dir;
	endfunction

	assign pidx    = item.address[1:0];
	assign bit_sel = item.write_data[3:1];

	always_comb begin
		latch_d = latch_q;
		dir_d   = dir_q;
		drive_d = drive_q;
		touched = '0;
		rd      = '0;
		if (item.action == ACT_READ) begin
			case (item.address)
				ADDR_PORT_A, ADDR_PORT_B, ADDR_PORT_C: begin
					rd = (latch_q[pidx] & ~dir_q[pidx]) | (item.pins[pidx] & dir_q[pidx]);
				end
				default: begin
					rd = READ_UNUSED;
				end
			endcase
		end else begin
			case (item.address)
				ADDR_PORT_A, ADDR_PORT_B, ADDR_PORT_C: begin
					latch_d[pidx] = item.write_data;
					drive_d[pidx] = eval_drive(item.write_data, dir_q[pidx]);
					touched[pidx] = 1'b1;
				end
				ADDR_CTL: begin
					if (item.write_data[CTL_MODE_SET_BIT]) begin
						// a nonzero group mode is ignored, nothing changes
						if (item.write_data[6:5] == 2'b00 && !item.write_data[2]) begin
							dir_d[PORT_A] = {8{item.write_data[CTL_DIR_A_BIT]}};
							dir_d[PORT_B] = {8{item.write_data[CTL_DIR_B_BIT]}};
							dir_d[PORT_C] = {{4{item.write_data[CTL_DIR_CU_BIT]}},
								{4{item.write_data[CTL_DIR_CL_BIT]}}};
							latch_d = '0;
							// cleared latches leave only the input bits high
							drive_d = dir_d;
							touched = '1;
						end
					end else begin
						latch_d[PORT_C][bit_sel] = item.write_data[0];
						drive_d[PORT_C] = eval_drive(latch_d[PORT_C], dir_q[PORT_C]);
						touched[PORT_C] = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res.read_data = rd;
		res.drive     = drive_d;
		res.touched   = touched;
		for (int p = 0; p < NUM_PORTS; p++) begin
			res.changed[p] = touched[p] ? (drive_q[p] ^ drive_d[p]) : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= '0;
			dir_q   <= '1;
			drive_q <= '0;
		end else if (advance) begin
			latch_q <= latch_d;
			dir_q   <= dir_d;
			drive_q <= drive_d;
		end
	end

	a_read_keeps_drive: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.action == ACT_READ |=> drive_q == $past(drive_q))
		else $error("read access changed a port drive");

	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.action == ACT_WRITE |-> res.read_data == 8'h00)
		else $error("write access returned nonzero read data");

	a_input_bits_high: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.touched[PORT_C] |=> (drive_q[PORT_C] & dir_q[PORT_C]) == dir_q[PORT_C])
		else $error("port c input bit not driven high after re-evaluation");

endmodule

// File: hdl/ppim0_outreg.sv
// ----------------------------------------------------------------------------
// ppim0_outreg
// Result register: holds one finished item until the output side takes it.
// ----------------------------------------------------------------------------
module ppim0_outreg
	import ppim0_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	input  logic out_ready,
	output logic free,
	output logic out_valid,
	output res_t res_q
);

	logic valid_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// File: hdl/parallel_io_port_mode0.sv
// ----------------------------------------------------------------------------
// parallel_io_port_mode0
// Three-port parallel I/O peripheral, basic mode 0, one bus access per item.
// ----------------------------------------------------------------------------
// Each item is one read or write at a 3-bit address and gives exactly one
// result. An item is registered on entry, decoded combinationally against the
// port state, and the result lands in an output register until it is taken;
// one item is taken every clock while the output side keeps out_ready high.
// Change masks compare the drives after the access with those before it;
// reads report zero masks and flags.
module parallel_io_port_mode0
	import ppim0_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [2:0] address,
	input  logic [7:0] write_data,
	input  logic [7:0] pins_a,
	input  logic [7:0] pins_b,
	input  logic [7:0] pins_c,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic [7:0] drive_a,
	output logic [7:0] drive_b,
	output logic [7:0] drive_c,
	output logic [7:0] changed_a,
	output logic [7:0] changed_b,
	output logic [7:0] changed_c,
	output logic       touched_a,
	output logic       touched_b,
	output logic       touched_c
);

	item_t item_s1;
	logic  valid_s1;
	logic  advance;
	logic  out_free;
	res_t  res_comb;
	res_t  res_q;

	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action     <= action;
			item_s1.address    <= address;
			item_s1.write_data <= write_data;
			item_s1.pins       <= {pins_c, pins_b, pins_a};
		end
	end

	ppim0_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.res     (res_comb)
	);

	ppim0_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res_in    (res_comb),
		.out_ready (out_ready),
		.free      (out_free),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign read_data = res_q.read_data;
	assign drive_a   = res_q.drive[PORT_A];
	assign drive_b   = res_q.drive[PORT_B];
	assign drive_c   = res_q.drive[PORT_C];
	assign changed_a = res_q.changed[PORT_A];
	assign changed_b = res_q.changed[PORT_B];
	assign changed_c = res_q.changed[PORT_C];
	assign touched_a = res_q.touched[PORT_A];
	assign touched_b = res_q.touched[PORT_B];
	assign touched_c = res_q.touched[PORT_C];

	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted item did not enter the input stage");

	a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stalled item lost or changed in the input stage");

	a_waiting_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_q))
		else $error("waiting result dropped or changed before it was taken");

endmodule
